// ===== rtl/core/kmi_pkg.sv =====
// ----------------------------------------------------------------------------
// kmi_pkg
// Shared constants, request codes and channel types of the keyframe
// matrix interpolator.
// ----------------------------------------------------------------------------
package kmi_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int FRAC_BITS = 16;

  // derived sizes
  localparam int KEY_W   = $clog2(MAX_KEYS);
  localparam int CNT_W   = $clog2(MAX_KEYS + 1);
  localparam int MAT_AW  = KEY_W + 4;
  localparam int FRAC_W  = FRAC_BITS + 1;
  localparam int DIFF_W  = 33;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

  // request codes
  localparam logic [1:0] REQ_TIME  = 2'd0;
  localparam logic [1:0] REQ_ELEM  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // configuration register indexes
  localparam logic CFG_KEY_COUNT   = 1'b0;
  localparam logic CFG_TARGET_NODE = 1'b1;

  // classified item from front to back
  typedef struct packed {
    logic [1:0]        req;
    logic [KEY_W-1:0]  slot;
    logic [3:0]        elem;
    logic signed [31:0] val;
  } item_t;

  // divider request and response
  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] num;
    logic signed [DIFF_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] frac;
  } div_rsp_t;

endpackage

// ===== rtl/core/kmi_front.sv =====
// ----------------------------------------------------------------------------
// kmi_front
// Accepts input items, drops unknown requests and out of range slots,
// and queues the rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module kmi_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type,
  input  logic [5:0]         key_index,
  input  logic [3:0]         element_index,
  input  logic signed [31:0] write_value,
  input  logic signed [31:0] query_time,
  output kmi_pkg::item_t     head,
  output logic               head_valid,
  input  logic               head_pop
);
  import kmi_pkg::*;

  item_t      q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       keep;
  logic       wr;
  logic       rd;
  item_t      item;

  // classify the incoming item
  always_comb begin
    keep = 1'b0;
    case (req_type)
      REQ_TIME, REQ_ELEM: keep = (32'(key_index) < MAX_KEYS);
      REQ_QUERY:          keep = 1'b1;
      default:            keep = 1'b0;
    endcase
    item.req  = req_type;
    item.slot = KEY_W'(key_index);
    item.elem = element_index;
    item.val  = (req_type == REQ_QUERY) ? query_time : write_value;
  end

  assign full       = (cnt == 2'd2);
  assign wr         = push && !full && keep;
  assign rd         = head_pop && (cnt != 2'd0);
  assign head_valid = (cnt != 2'd0);
  assign head       = q[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (wr) begin
      q[wptr] <= item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

endmodule

// ===== rtl/core/kmi_div.sv =====
// ----------------------------------------------------------------------------
// kmi_div
// Serial restoring divider for the blend weight: one quotient bit a cycle,
// result truncated toward zero and clamped to [0, 1].
// ----------------------------------------------------------------------------
module kmi_div (
  input  logic              clk,
  input  logic              rst,
  input  kmi_pkg::div_req_t req,
  output kmi_pkg::div_rsp_t rsp
);
  import kmi_pkg::*;

  localparam int DW = DIFF_W + 1 + FRAC_BITS;
  localparam int CW = $clog2(FRAC_BITS + 1);

  logic [DIFF_W-1:0] absn;
  logic [DIFF_W-1:0] absd;
  logic [DW-1:0]     mn;
  logic [DW-1:0]     md;
  logic              neg;
  logic              ovf;
  logic              ge;
  logic [DW-1:0]     rem;
  logic [DW-1:0]     dsh;
  logic [FRAC_W-1:0] q;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;

  // operand magnitudes and early outcomes
  always_comb begin
    absn = req.num[DIFF_W-1] ? DIFF_W'(-req.num) : DIFF_W'(req.num);
    absd = req.den[DIFF_W-1] ? DIFF_W'(-req.den) : DIFF_W'(req.den);
    mn   = DW'(absn) << FRAC_BITS;
    md   = DW'(absd);
    neg  = (req.num[DIFF_W-1] != req.den[DIFF_W-1]) && (req.num != '0);
    ovf  = (mn >= (md << (FRAC_BITS + 1)));
    ge   = (rem >= dsh);
  end

  // iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (neg) begin
          q    <= '0;
          done <= 1'b1;
        end else if (ovf) begin
          q    <= FRAC_ONE;
          done <= 1'b1;
        end else begin
          rem  <= mn;
          dsh  <= md << FRAC_BITS;
          cnt  <= CW'(FRAC_BITS);
          q    <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (ge) rem <= rem - dsh;
        q   <= {q[FRAC_W-2:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.frac = (q > FRAC_ONE) ? FRAC_ONE : q;

endmodule

// ===== rtl/core/kmi_back.sv =====
// ----------------------------------------------------------------------------
// kmi_back
// Holds the key tables, walks the search cursor, drives the divider and
// blends the sixteen elements into a small result queue.
// ----------------------------------------------------------------------------
module kmi_back (
  input  logic               clk,
  input  logic               rst,
  input  kmi_pkg::item_t     head,
  input  logic               head_valid,
  output logic               head_pop,
  input  logic [6:0]         key_count,
  output kmi_pkg::div_req_t  div_req,
  input  kmi_pkg::div_rsp_t  div_rsp,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         out_element_index,
  output logic signed [31:0] element_value,
  output logic               last,
  output logic               degenerate
);
  import kmi_pkg::*;

  localparam int P_W   = 32 + FRAC_W + 1;
  localparam int SUM_W = P_W + 1;
  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sh7FFFFFFF);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sh80000000);

  typedef enum logic [2:0] {S_IDLE, S_CHK, S_WALK, S_T0, S_DIV, S_EMIT} state_t;

  typedef struct packed {
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic               deg;
  } res_t;

  logic signed [31:0] key_times    [MAX_KEYS];
  logic signed [31:0] key_matrices [MAX_KEYS * 16];

  state_t             state;
  logic [KEY_W-1:0]   cur;
  logic [KEY_W-1:0]   cursor;
  logic [CNT_W-1:0]   n;
  logic signed [31:0] qt;
  logic signed [31:0] tc;
  logic signed [31:0] tdata;
  logic [FRAC_W-1:0]  frac;
  logic               degen;
  logic [KEY_W-1:0]   ka;
  logic [KEY_W-1:0]   kb;
  logic [3:0]         k;

  logic [CNT_W-1:0]   n_c;
  logic [KEY_W-1:0]   c0;
  logic               t_rd;
  logic [KEY_W-1:0]   t_addr;
  logic               advance;
  logic signed [DIFF_W-1:0] dden;
  logic signed [DIFF_W-1:0] dnum;
  logic               issue;
  logic [FRAC_W-1:0]  wa;

  // blend pipeline
  logic               s1;
  logic               s2;
  logic [3:0]         k1;
  logic [3:0]         k2;
  logic               g1;
  logic               g2;
  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [P_W-1:0]   pa;
  logic signed [P_W-1:0]   pb;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] shv;
  logic signed [31:0]      sat;

  // result queue
  res_t       rq [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] cnt;
  logic       rd;

  // effective key count and starting cursor
  always_comb begin
    if (key_count == 7'd0) begin
      n_c = CNT_W'(1);
    end else if (32'(key_count) > MAX_KEYS) begin
      n_c = CNT_W'(MAX_KEYS);
    end else begin
      n_c = CNT_W'(key_count);
    end
    c0 = (CNT_W'(cursor) >= n_c) ? '0 : cursor;
  end

  // sequencing control
  always_comb begin
    head_pop = (state == S_IDLE) && head_valid;
    advance  = (CNT_W'(cur) < (n - CNT_W'(1))) && (qt > tdata);
    dden     = DIFF_W'(tc) - DIFF_W'(tdata);
    dnum     = DIFF_W'(qt) - DIFF_W'(tdata);
    t_rd     = 1'b0;
    t_addr   = cur;
    case (state)
      S_IDLE: begin
        if (head_pop && head.req == REQ_QUERY) begin
          t_rd   = 1'b1;
          t_addr = c0;
        end
      end
      S_CHK: begin
        t_rd   = 1'b1;
        t_addr = (qt < tdata) ? '0 : cur;
      end
      S_WALK: begin
        if (advance) begin
          t_rd   = 1'b1;
          t_addr = cur + KEY_W'(1);
        end else if (cur != '0) begin
          t_rd   = 1'b1;
          t_addr = cur - KEY_W'(1);
        end
      end
      default: begin
        t_rd = 1'b0;
      end
    endcase
    div_req.start = (state == S_T0) && (dden != '0);
    div_req.num   = dnum;
    div_req.den   = dden;
    issue = (state == S_EMIT) && ((4'(cnt) + 4'(s1) + 4'(s2)) < 4'd4);
    wa    = FRAC_ONE - frac;
  end

  // key time table
  always_ff @(posedge clk) begin
    if (head_pop && head.req == REQ_TIME) begin
      key_times[head.slot] <= head.val;
    end
    if (t_rd) begin
      tdata <= key_times[t_addr];
    end
  end

  // key matrix table, two reads per element
  always_ff @(posedge clk) begin
    if (head_pop && head.req == REQ_ELEM) begin
      key_matrices[{head.slot, head.elem}] <= head.val;
    end
    if (issue) begin
      ma <= key_matrices[{ka, k}];
      mb <= key_matrices[{kb, k}];
    end
  end

  // query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cursor <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (head_pop && head.req == REQ_QUERY) begin
            n     <= n_c;
            cur   <= c0;
            qt    <= head.val;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (qt < tdata) cur <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          if (advance) begin
            cur <= cur + KEY_W'(1);
          end else begin
            cursor <= cur;
            tc     <= tdata;
            if (cur == '0) begin
              ka    <= '0;
              kb    <= '0;
              frac  <= '0;
              degen <= 1'b0;
              k     <= '0;
              state <= S_EMIT;
            end else begin
              ka    <= cur - KEY_W'(1);
              kb    <= cur;
              state <= S_T0;
            end
          end
        end
        S_T0: begin
          k <= '0;
          if (dden == '0) begin
            frac  <= FRAC_ONE;
            degen <= 1'b1;
            state <= S_EMIT;
          end else begin
            degen <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            frac  <= div_rsp.frac;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (issue) begin
            k <= k + 4'd1;
            if (k == 4'd15) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= 1'b0;
      s2 <= 1'b0;
    end else begin
      s1 <= issue;
      s2 <= s1;
    end
  end

  // weighted products
  always_ff @(posedge clk) begin
    k1 <= k;
    g1 <= degen;
    k2 <= k1;
    g2 <= g1;
    pa <= P_W'(ma * $signed({1'b0, wa}));
    pb <= P_W'(mb * $signed({1'b0, frac}));
  end

  // round and saturate
  always_comb begin
    sum = SUM_W'(pa) + SUM_W'(pb) + ROUND;
    shv = sum >>> FRAC_BITS;
    if (shv > SAT_HI) begin
      sat = 32'sh7FFFFFFF;
    end else if (shv < SAT_LO) begin
      sat = 32'sh80000000;
    end else begin
      sat = 32'(shv);
    end
  end

  // result queue
  assign rd = pop && (cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (s2) begin
      rq[wptr] <= '{idx: k2, val: sat, deg: g2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (s2) wptr <= wptr + 2'd1;
      if (rd) rptr <= rptr + 2'd1;
      cnt <= cnt + 3'(s2) - 3'(rd);
    end
  end

  assign empty             = (cnt == 3'd0);
  assign out_element_index = rq[rptr].idx;
  assign element_value     = rq[rptr].val;
  assign last              = (rq[rptr].idx == 4'd15);
  assign degenerate        = rq[rptr].deg;

endmodule

// ===== rtl/core/keyframe_matrix_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_matrix_interpolator
// Keyframe table with cursor search and linear blend of 4x4 matrices.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  input    | push / full        | req_type key_index element_index
//           |                    | write_value query_time
//  result   | empty / pop        | node_id out_element_index element_value
//           |                    | last degenerate
//  config   | cfg_write          | cfg_index cfg_data
//
//  A write item is taken by the back end in its idle state. A query walks
//  the key time table from the cursor, runs the serial divider when the
//  key times differ (the divider skips its iteration when the weight
//  clamps to 0 or 1 up front), and issues the sixteen elements, one per
//  cycle while the result queue has room, into a four-entry result queue.
//  Reset is synchronous and clears the queues and the cursor.
//  A two-entry input queue lets writes and queries arrive while a query
//  runs; a stalled result side holds the element issue.
module keyframe_matrix_interpolator (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type,
  input  logic [5:0]         key_index,
  input  logic [3:0]         element_index,
  input  logic signed [31:0] write_value,
  input  logic signed [31:0] query_time,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        node_id,
  output logic [3:0]         out_element_index,
  output logic signed [31:0] element_value,
  output logic               last,
  output logic               degenerate,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import kmi_pkg::*;

  logic [6:0]  key_count;
  logic [15:0] target_node;
  item_t       head;
  logic        head_valid;
  logic        head_pop;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count   <= 7'd1;
      target_node <= 16'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KEY_COUNT:   key_count   <= cfg_data[6:0];
        CFG_TARGET_NODE: target_node <= cfg_data;
        default:         key_count   <= key_count;
      endcase
    end
  end

  assign node_id = target_node;

  kmi_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .req_type      (req_type),
    .key_index     (key_index),
    .element_index (element_index),
    .write_value   (write_value),
    .query_time    (query_time),
    .head          (head),
    .head_valid    (head_valid),
    .head_pop      (head_pop)
  );

  kmi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  kmi_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .head_valid        (head_valid),
    .head_pop          (head_pop),
    .key_count         (key_count),
    .div_req           (div_req),
    .div_rsp           (div_rsp),
    .empty             (empty),
    .pop               (pop),
    .out_element_index (out_element_index),
    .element_value     (element_value),
    .last              (last),
    .degenerate        (degenerate)
  );

endmodule

// ===== rtl/core/kmi_checker.sv =====
// ----------------------------------------------------------------------------
// kmi_checker
// Port-level checks on the result run of the keyframe matrix interpolator.
// ----------------------------------------------------------------------------
module kmi_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [3:0]  out_element_index,
  input logic [31:0] element_value,
  input logic        last,
  input logic        degenerate
);

  // last marks the final element of a run
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (out_element_index == 4'd15))
    else $error("last without final element index");

  // elements of a run come out in order
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=>
      (empty || out_element_index == 4'($past(out_element_index) + 4'd1)))
    else $error("element index out of sequence");

  // degenerate flag is fixed over a run
  a_run_degen: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> (empty || degenerate == $past(degenerate)))
    else $error("degenerate flag changed within a run");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(element_value)))
    else $error("waiting result changed");

endmodule

bind keyframe_matrix_interpolator kmi_checker u_kmi_checker (
  .clk               (clk),
  .rst               (rst),
  .empty             (empty),
  .pop               (pop),
  .out_element_index (out_element_index),
  .element_value     (element_value),
  .last              (last),
  .degenerate        (degenerate)
);
